>>> hw/rtl/maps_pkg.sv
package maps_pkg;

	localparam int MAX_DIM_DEF = 32;
	localparam int LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_WALL = 8'h23;
	localparam logic [7:0] CH_START = 8'h53;
	localparam logic [7:0] CH_END = 8'h45;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NO_PATH = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_NO_START = 2'd3;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;
	localparam logic [1:0] DIR_UP = 2'd3;

	typedef struct packed {
		logic       operation;
		logic [4:0] cell_row;
		logic [4:0] cell_col;
		logic [7:0] cell_char;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      path_count;
		logic [LEN_W-1:0] shortest_length;
		logic [LEN_W-1:0] longest_length;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic scan_init;   // reset scan position, flags
		logic scan_rd;     // issue grid read at scan position
		logic scan_chk;    // check registered char, advance
		logic clr_step;    // clear one mark word
		logic push_start;
		logic eval;        // try next direction, or read parent entry
		logic act;         // act on neighbor data
		logic pop;         // drop top level
		logic load_res;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic bad_seen;
		logic start_seen;
		logic clr_last;
		logic top_done;    // all four directions of top level tried
		logic last_level;  // only the start level is left
	} dp_sts_t;

endpackage

>>> hw/rtl/maps_datapath.sv
module maps_datapath #(
	parameter int MAX_DIM = maps_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_fire,
	input  maps_pkg::request_t req,
	input  logic [5:0]         grid_rows_q,
	input  logic [5:0]         grid_cols_q,
	input  maps_pkg::dp_cmd_t  cmd,
	output maps_pkg::dp_sts_t  sts,
	output maps_pkg::result_t  res
);
	localparam int DW = $clog2(MAX_DIM);
	localparam int AW = 2 * DW;
	localparam int NADDR = 1 << AW;
	localparam int NROW = 1 << DW;
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int SW = AW + 1;
	localparam int LW = maps_pkg::LEN_W;

	logic [7:0]         grid_mem [NADDR];
	logic [AW+2:0]      stk_mem [NADDR];   // {row, col, next dir}
	logic [MAX_DIM-1:0] mark_mem [NROW];   // one row of marks per word

	logic [DW:0] rows_use, cols_use;
	always_comb begin
		rows_use = (grid_rows_q == 6'd0) ? (DW+1)'(1) :
			(32'(grid_rows_q) > MAX_DIM) ? (DW+1)'(MAX_DIM) : (DW+1)'(grid_rows_q);
		cols_use = (grid_cols_q == 6'd0) ? (DW+1)'(1) :
			(32'(grid_cols_q) > MAX_DIM) ? (DW+1)'(MAX_DIM) : (DW+1)'(grid_cols_q);
	end

	logic [DW-1:0] sr_q, sc_q, st_r_q, st_c_q;
	logic [DW-1:0] cur_r_q, cur_c_q, nr_q, nc_q;
	logic [2:0]    cur_d_q;
	logic [SW-1:0] depth_q;
	logic [DW-1:0] clr_q;
	logic          nb_ok_q;
	logic          bad_q, start_q;
	logic [31:0]   cnt_q;
	logic [LW-1:0] short_q, long_q;
	logic          exhausted;

	assign exhausted = cur_d_q[2];

	// neighbor of top level in its next direction
	logic [DW-1:0] nb_r, nb_c;
	logic          nb_ok;
	always_comb begin
		nb_r = cur_r_q;
		nb_c = cur_c_q;
		nb_ok = 1'b0;
		case (cur_d_q[1:0])
			maps_pkg::DIR_RIGHT: begin
				nb_c = cur_c_q + 1'b1;
				nb_ok = (DW+1)'(cur_c_q) + 1'b1 < cols_use;
			end
			maps_pkg::DIR_DOWN: begin
				nb_r = cur_r_q + 1'b1;
				nb_ok = (DW+1)'(cur_r_q) + 1'b1 < rows_use;
			end
			maps_pkg::DIR_LEFT: begin
				nb_c = cur_c_q - 1'b1;
				nb_ok = cur_c_q != '0;
			end
			maps_pkg::DIR_UP: begin
				nb_r = cur_r_q - 1'b1;
				nb_ok = cur_r_q != '0;
			end
			default: nb_ok = 1'b0;
		endcase
	end

	// grid port: one write/read address
	logic [7:0]    grid_rd_q;
	logic          gwe;
	logic [AW-1:0] gaddr;
	logic [DW:0]   rq_ext, cq_ext;
	assign rq_ext = (DW+1)'(req.cell_row);
	assign cq_ext = (DW+1)'(req.cell_col);
	assign gwe = req_fire && req.operation == maps_pkg::OP_WRITE &&
		32'(req.cell_row) < MAX_DIM && 32'(req.cell_col) < MAX_DIM;

	always_comb begin
		if (gwe) gaddr = {rq_ext[DW-1:0], cq_ext[DW-1:0]};
		else if (cmd.scan_rd) gaddr = {sr_q, sc_q};
		else gaddr = {nb_r, nb_c};
	end

	always_ff @(posedge clk) begin
		if (gwe) grid_mem[gaddr] <= req.cell_char;
		if (cmd.scan_rd || (cmd.eval && !exhausted)) grid_rd_q <= grid_mem[gaddr];
	end

	// neighbor action
	logic [MAX_DIM-1:0] mark_rd_q;
	logic               hit, do_push, do_count;
	assign hit = nb_ok_q && !mark_rd_q[nc_q];
	assign do_push = cmd.act && hit && grid_rd_q == maps_pkg::CH_DOT &&
		32'(depth_q) < CELLS;
	assign do_count = cmd.act && hit && grid_rd_q == maps_pkg::CH_END;

	// mark memory: read-modify-write of one row word
	logic               mark_we;
	logic [DW-1:0]      mark_wa, mark_ra;
	logic [MAX_DIM-1:0] mark_wd;
	always_comb begin
		mark_we = 1'b0;
		mark_wa = cur_r_q;
		mark_wd = '0;
		if (cmd.clr_step) begin
			mark_we = 1'b1;
			mark_wa = clr_q;
		end else if (cmd.push_start) begin
			mark_we = 1'b1;
			mark_wa = st_r_q;
			mark_wd = MAX_DIM'(1) << st_c_q;
		end else if (do_push) begin
			mark_we = 1'b1;
			mark_wa = nr_q;
			mark_wd = mark_rd_q | (MAX_DIM'(1) << nc_q);
		end else if (cmd.pop) begin
			mark_we = 1'b1;
			mark_wa = cur_r_q;
			mark_wd = mark_rd_q & ~(MAX_DIM'(1) << cur_c_q);
		end
	end
	// a pop needs the top cell's own row, a try needs the neighbor's
	assign mark_ra = exhausted ? cur_r_q : nb_r;
	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (cmd.eval) mark_rd_q <= mark_mem[mark_ra];
	end

	// stack memory holds the levels below the top; the top lives in cur_*
	logic [AW-1:0] stk_wa, stk_ra;
	logic [AW+2:0] stk_rd_q;
	assign stk_wa = AW'(depth_q - 1'b1);
	assign stk_ra = AW'(depth_q - 2'd2);
	always_ff @(posedge clk) begin
		if (do_push) stk_mem[stk_wa] <= {cur_r_q, cur_c_q, cur_d_q};
		if (cmd.eval && exhausted) stk_rd_q <= stk_mem[stk_ra];
	end

	logic [SW:0]   len;
	logic [LW-1:0] len_sat;
	assign len = (SW+1)'(depth_q) + 1'b1;
	assign len_sat = (32'(len) > 32'(maps_pkg::LEN_MAX)) ? maps_pkg::LEN_MAX : LW'(len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q <= '0;
			sc_q <= '0;
			st_r_q <= '0;
			st_c_q <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			cur_d_q <= '0;
			nr_q <= '0;
			nc_q <= '0;
			nb_ok_q <= 1'b0;
			depth_q <= '0;
			clr_q <= '0;
			cnt_q <= '0;
			short_q <= '0;
			long_q <= '0;
			bad_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				sr_q <= '0;
				sc_q <= '0;
				clr_q <= '0;
				bad_q <= 1'b0;
				start_q <= 1'b0;
				cnt_q <= '0;
				short_q <= '0;
				long_q <= '0;
			end
			if (cmd.scan_chk) begin
				if (grid_rd_q != maps_pkg::CH_DOT && grid_rd_q != maps_pkg::CH_WALL &&
						grid_rd_q != maps_pkg::CH_START && grid_rd_q != maps_pkg::CH_END)
					bad_q <= 1'b1;
				if (grid_rd_q == maps_pkg::CH_START && !start_q) begin
					start_q <= 1'b1;
					st_r_q <= sr_q;
					st_c_q <= sc_q;
				end
				if ((DW+1)'(sc_q) + 1'b1 >= cols_use) begin
					sc_q <= '0;
					sr_q <= sr_q + 1'b1;
				end else begin
					sc_q <= sc_q + 1'b1;
				end
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.push_start) begin
				cur_r_q <= st_r_q;
				cur_c_q <= st_c_q;
				cur_d_q <= '0;
				depth_q <= SW'(1);
			end
			if (cmd.eval && !exhausted) begin
				nr_q <= nb_r;
				nc_q <= nb_c;
				nb_ok_q <= nb_ok;
				cur_d_q <= cur_d_q + 1'b1;
			end
			if (do_count) begin
				if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
				if (short_q == '0 || len_sat < short_q) short_q <= len_sat;
				if (len_sat > long_q) long_q <= len_sat;
			end
			if (do_push) begin
				cur_r_q <= nr_q;
				cur_c_q <= nc_q;
				cur_d_q <= '0;
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.pop) begin
				{cur_r_q, cur_c_q, cur_d_q} <= stk_rd_q;
				depth_q <= depth_q - 1'b1;
			end
		end
	end

	assign sts.scan_last = (DW+1)'(sr_q) + 1'b1 >= rows_use &&
		(DW+1)'(sc_q) + 1'b1 >= cols_use;
	assign sts.bad_seen = bad_q;
	assign sts.start_seen = start_q;
	assign sts.clr_last = 32'(clr_q) == MAX_DIM - 1;
	assign sts.top_done = exhausted;
	assign sts.last_level = depth_q == SW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res.path_count <= (bad_q || !start_q) ? '0 : cnt_q;
			res.shortest_length <= (bad_q || !start_q) ? '0 : short_q;
			res.longest_length <= (bad_q || !start_q) ? '0 : long_q;
			res.status <= bad_q ? maps_pkg::ST_INVALID :
				!start_q ? maps_pkg::ST_NO_START :
				(cnt_q != '0) ? maps_pkg::ST_FOUND : maps_pkg::ST_NO_PATH;
		end
	end
endmodule

>>> hw/rtl/maps_ctrl.sv
module maps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              search_go,
	input  maps_pkg::dp_sts_t sts,
	output maps_pkg::dp_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCHK, S_CLR, S_PUSH, S_EVAL, S_ACT, S_POP, S_RES, S_OUT
	} state_t;
	state_t st_q;

	always_comb begin
		cmd = '0;
		case (st_q)
			S_SRD:   cmd.scan_rd = 1'b1;
			S_SCHK:  cmd.scan_chk = 1'b1;
			S_CLR:   cmd.clr_step = 1'b1;
			S_PUSH:  cmd.push_start = 1'b1;
			S_EVAL:  cmd.eval = 1'b1;
			S_ACT:   cmd.act = 1'b1;
			S_POP:   cmd.pop = 1'b1;
			S_RES:   cmd.load_res = 1'b1;
			default: cmd = '0;
		endcase
		if (st_q == S_IDLE && search_go) cmd.scan_init = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (search_go) begin
					st_q <= S_SRD;
					busy <= 1'b1;
				end
				S_SRD: st_q <= S_SCHK;
				S_SCHK: begin
					if (sts.scan_last) st_q <= S_CLR;
					else st_q <= S_SRD;
				end
				S_CLR: if (sts.clr_last)
					st_q <= (sts.bad_seen || !sts.start_seen) ? S_RES : S_PUSH;
				S_PUSH: st_q <= S_EVAL;
				S_EVAL: st_q <= sts.top_done ? S_POP : S_ACT;
				S_ACT: st_q <= S_EVAL;
				S_POP: st_q <= sts.last_level ? S_RES : S_EVAL;
				S_RES: st_q <= S_OUT;
				S_OUT: begin
					st_q <= S_IDLE;
					busy <= 1'b0;
					done <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/maze_all_paths_search_unit.sv
// Channel  | Signals                                    | Handshake
// request  | start, busy, req                           | accepted when start && !busy
// result   | done, res                                  | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | accepted when valid && ready
// A cell write leaves busy low; the next request may follow at once.
// A search holds busy while it scans the in-use area of R*C cells, reading and
// checking each cell, clears the marks one row word at a time, and then searches
// step by step (a direction tried or a level popped); a maze that is invalid or
// has no start skips the search steps. done rises as busy falls.
// Reset clears the state registers, not the memories or res; the receiver cannot stall results.
module maze_all_paths_search_unit #(
	parameter int MAX_DIM = maps_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  maps_pkg::request_t req,
	output logic               done,
	output maps_pkg::result_t  res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data
);
	logic [5:0] rows_q, cols_q;
	logic fire;
	maps_pkg::dp_cmd_t cmd;
	maps_pkg::dp_sts_t sts;

	assign fire = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd32;
			cols_q <= 6'd32;
		end else if (cfg_valid) begin
			if (cfg_index == maps_pkg::CFG_ROWS) rows_q <= cfg_data;
			else cols_q <= cfg_data;
		end
	end

	maps_ctrl u_ctrl (
		.clk, .arst_n,
		.search_go(fire && req.operation == maps_pkg::OP_SEARCH),
		.sts, .cmd, .busy, .done
	);

	maps_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk, .arst_n, .req_fire(fire), .req,
		.grid_rows_q(rows_q), .grid_cols_q(cols_q),
		.cmd, .sts, .res
	);
endmodule

>>> hw/rtl/maps_checker.sv
module maps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input maps_pkg::request_t req,
	input logic               done
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without search");
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == maps_pkg::OP_SEARCH) |=> busy)
		else $error("search request not taken");
endmodule

bind maze_all_paths_search_unit maps_checker u_chk (
	.clk, .arst_n, .start, .busy, .req, .done
);
